// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tct_pkg.sv =====
`timescale 1ns / 1ps

package tct_pkg;

    localparam int MAX_TIERS_DEF     = 16;
    localparam int MAX_RUN_FILES_DEF = 1023;

    localparam int RUN_FILES_W = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int COUNT_CFG_W = 5;
    localparam int PCT_W       = 10;
    localparam int TAKEN_W     = 5;

    localparam logic [6:0] PERCENT_BASE = 7'd100;

    localparam logic [COUNT_CFG_W-1:0] MIN_TIER_COUNT_RST  = 5'd6;
    localparam logic [PCT_W-1:0]       MAX_AMP_PERCENT_RST = 10'd200;
    localparam logic [PCT_W-1:0]       SIZE_RATIO_RST      = 10'd50;
    localparam logic [COUNT_CFG_W-1:0] MIN_MERGE_WIDTH_RST = 5'd2;
    localparam logic [COUNT_CFG_W-1:0] MAX_MERGE_WIDTH_RST = 5'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_TIER_COUNT     = 3'd0,
        CFG_MAX_AMP_PERCENT    = 3'd1,
        CFG_SIZE_RATIO_PERCENT = 3'd2,
        CFG_MIN_MERGE_WIDTH    = 3'd3,
        CFG_MAX_MERGE_WIDTH    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DEC_NONE        = 2'd0,
        DEC_SPACE_AMP   = 2'd1,
        DEC_SIZE_RATIO  = 2'd2,
        DEC_REDUCE_RUNS = 2'd3
    } t_decision;

    typedef struct packed {
        logic [RUN_FILES_W-1:0] run_files;
        logic                   last_tier;
        logic                   level0_busy;
    } t_tier_item;

    typedef struct packed {
        t_decision          decision;
        logic [TAKEN_W-1:0] tiers_taken;
        logic               bottom_included;
        logic               tier_overflow;
    } t_result;

endpackage

// ===== hdl/tct_item_if.sv =====
`timescale 1ns / 1ps

interface tct_item_if;
    logic                valid;
    logic                ready;
    tct_pkg::t_tier_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/tct_result_if.sv =====
`timescale 1ns / 1ps

interface tct_result_if;
    logic             valid;
    logic             ready;
    tct_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/tiered_compaction_trigger.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Payload                                          Moves on
// i_item     in   run_files, last_tier, level0_busy                valid & ready
// o_result   out  decision, tiers_taken, bottom_included, overflow valid & ready
// i_cfg_*    in   register index and data                          i_cfg_we
//
// One tier item per clock. An accepted item sits in the input register; the tier
// state update, the size-ratio compare and the final decision are done while it
// is there and the result register loads as it advances, so a result passes
// through the input and result registers in turn after its last tier is accepted.
// Synchronous active-low reset restores the register defaults and empties the list.
// A stalled result only holds up a following last-tier item; other tiers flow on.
module tiered_compaction_trigger #(
    parameter int MAX_TIERS     = tct_pkg::MAX_TIERS_DEF,
    parameter int MAX_RUN_FILES = tct_pkg::MAX_RUN_FILES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tct_item_if.sink                       i_item,
    tct_result_if.source                   o_result
);

    localparam int RFW  = tct_pkg::RUN_FILES_W;
    localparam int CW   = $clog2(MAX_TIERS + 1);
    localparam int CMPW = (CW > tct_pkg::COUNT_CFG_W) ? CW : tct_pkg::COUNT_CFG_W;
    localparam int SW   = RFW + $clog2(MAX_TIERS);
    localparam int PW   = SW + 11;
    localparam logic [RFW-1:0] RF_MAX =
        (MAX_RUN_FILES >= (1 << RFW) - 1) ? {RFW{1'b1}} : RFW'(MAX_RUN_FILES);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_TIERS);

    // configuration registers
    logic [tct_pkg::COUNT_CFG_W-1:0] r_min_tier_count;
    logic [tct_pkg::PCT_W-1:0]       r_max_amp;
    logic [tct_pkg::PCT_W-1:0]       r_ratio;
    logic [tct_pkg::COUNT_CFG_W-1:0] r_min_width;
    logic [tct_pkg::COUNT_CFG_W-1:0] r_max_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_tier_count <= tct_pkg::MIN_TIER_COUNT_RST;
            r_max_amp        <= tct_pkg::MAX_AMP_PERCENT_RST;
            r_ratio          <= tct_pkg::SIZE_RATIO_RST;
            r_min_width      <= tct_pkg::MIN_MERGE_WIDTH_RST;
            r_max_width      <= tct_pkg::MAX_MERGE_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (tct_pkg::t_cfg_idx'(i_cfg_idx))
                tct_pkg::CFG_MIN_TIER_COUNT:
                    r_min_tier_count <= i_cfg_data[tct_pkg::COUNT_CFG_W-1:0];
                tct_pkg::CFG_MAX_AMP_PERCENT:    r_max_amp <= i_cfg_data;
                tct_pkg::CFG_SIZE_RATIO_PERCENT: r_ratio   <= i_cfg_data;
                tct_pkg::CFG_MIN_MERGE_WIDTH:
                    r_min_width <= i_cfg_data[tct_pkg::COUNT_CFG_W-1:0];
                tct_pkg::CFG_MAX_MERGE_WIDTH:
                    r_max_width <= i_cfg_data[tct_pkg::COUNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic                r_in_valid;
    tct_pkg::t_tier_item r_in;
    logic                w_advance;

    assign w_advance    = r_in_valid && (!r_in.last_tier || !o_result.valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
    end

    // list state: r_total sums the run files of all counted tiers, r_prefix all but the newest
    logic [CW-1:0]  r_count;
    logic [SW-1:0]  r_total;
    logic [SW-1:0]  r_prefix;
    logic [RFW-1:0] r_last;
    logic [CW-1:0]  r_hit_idx;
    logic           r_hit_found;
    logic           r_overflow;

    logic [RFW-1:0]  w_rf;
    logic            w_take;
    logic [10:0]     w_ratio_sum;
    logic [PW-1:0]   w_rf_x100;
    logic [PW-1:0]   w_prefix_xr;
    logic            w_hit;
    logic [CW-1:0]   w_n;
    logic [SW-1:0]   w_e;
    logic [RFW-1:0]  w_b;
    logic            w_hit_found;
    logic [CW-1:0]   w_hit_idx;
    logic            w_ovf;
    logic [PW-1:0]   w_e_x100;
    logic [PW-1:0]   w_amp_b;
    logic            w_amp;
    logic [CMPW-1:0] w_n_ext;
    logic [CMPW-1:0] w_hit_ext;
    logic [CMPW-1:0] w_reduce;
    tct_pkg::t_result n_result;

    always_comb begin
        w_rf        = (r_in.run_files > RF_MAX) ? RF_MAX : r_in.run_files;
        w_take      = (r_count != COUNT_FULL);
        w_ratio_sum = 11'(r_ratio) + 11'(tct_pkg::PERCENT_BASE);
        w_rf_x100   = PW'(w_rf) * PW'(tct_pkg::PERCENT_BASE);
        w_prefix_xr = PW'(r_total) * PW'(w_ratio_sum);
        w_hit = (r_count != '0) && !r_hit_found && (r_total != '0)
             && (CMPW'(r_count) >= CMPW'(r_min_width))
             && (w_rf_x100 > w_prefix_xr);

        // view of the list once this tier is counted (or dropped when full)
        if (w_take) begin
            w_n         = r_count + CW'(1);
            w_e         = r_total;
            w_b         = w_rf;
            w_hit_found = r_hit_found || w_hit;
            w_hit_idx   = w_hit ? r_count : r_hit_idx;
            w_ovf       = r_overflow;
        end else begin
            w_n         = r_count;
            w_e         = r_prefix;
            w_b         = r_last;
            w_hit_found = r_hit_found;
            w_hit_idx   = r_hit_idx;
            w_ovf       = 1'b1;
        end

        w_e_x100 = PW'(w_e) * PW'(tct_pkg::PERCENT_BASE);
        w_amp_b  = PW'(r_max_amp) * PW'(w_b);
        w_amp    = ((w_b != '0) && (w_e_x100 >= w_amp_b))
                || ((w_b == '0) && (r_max_amp == '0));

        w_n_ext   = CMPW'(w_n);
        w_hit_ext = CMPW'(w_hit_idx);
        w_reduce  = ((r_max_width != '0) && (CMPW'(r_max_width) < w_n_ext))
                  ? CMPW'(r_max_width) : w_n_ext;

        n_result.tier_overflow = w_ovf;
        if (r_in.level0_busy || (w_n_ext < CMPW'(r_min_tier_count))) begin
            n_result.decision        = tct_pkg::DEC_NONE;
            n_result.tiers_taken     = '0;
            n_result.bottom_included = 1'b0;
        end else if (w_amp) begin
            n_result.decision        = tct_pkg::DEC_SPACE_AMP;
            n_result.tiers_taken     = w_n_ext[tct_pkg::TAKEN_W-1:0];
            n_result.bottom_included = 1'b1;
        end else if (w_hit_found) begin
            n_result.decision        = tct_pkg::DEC_SIZE_RATIO;
            n_result.tiers_taken     = w_hit_ext[tct_pkg::TAKEN_W-1:0];
            n_result.bottom_included = 1'b0;
        end else begin
            n_result.decision        = tct_pkg::DEC_REDUCE_RUNS;
            n_result.tiers_taken     = w_reduce[tct_pkg::TAKEN_W-1:0];
            n_result.bottom_included = (w_n_ext <= w_reduce);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_advance && r_in.last_tier)) begin
            r_count     <= '0;
            r_total     <= '0;
            r_prefix    <= '0;
            r_last      <= '0;
            r_hit_idx   <= '0;
            r_hit_found <= 1'b0;
            r_overflow  <= 1'b0;
        end else if (w_advance) begin
            r_count     <= w_n;
            r_hit_idx   <= w_hit_idx;
            r_hit_found <= w_hit_found;
            r_overflow  <= w_ovf;
            if (w_take) begin
                r_prefix <= r_total;
                r_total  <= r_total + SW'(w_rf);
                r_last   <= w_rf;
            end
        end
    end

    // result register
    logic             r_out_valid;
    tct_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in.last_tier) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in.last_tier) begin
            r_out <= n_result;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule

// ===== hdl/tct_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tct_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input tct_pkg::t_result i_out_payload
);

    logic w_none;
    logic w_ratio;
    logic w_stall;

    assign w_none  = i_out_valid && (i_out_payload.decision == tct_pkg::DEC_NONE);
    assign w_ratio = i_out_valid && (i_out_payload.decision == tct_pkg::DEC_SIZE_RATIO);
    assign w_stall = i_out_valid && !i_out_ready;

    // no merge means nothing taken and no bottom tier
    `ASSERT_IMPLY(a_none_empty, i_clk, i_rst_n, w_none, (i_out_payload.tiers_taken == '0) && !i_out_payload.bottom_included, "none decision carries a merge")
    // a size-ratio merge stops above the bottom tier
    `ASSERT_IMPLY(a_ratio_no_bottom, i_clk, i_rst_n, w_ratio, !i_out_payload.bottom_included, "size-ratio merge includes bottom tier")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid, "result item dropped while stalled")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable(i_out_payload), "stalled result item changed")

endmodule

bind tiered_compaction_trigger tct_checker u_tct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DIRECTED_ROWS   = 25;

    typedef struct {
        tct_pkg::t_tier_item item;
        bit                  typed;
        tct_pkg::t_result    want;
    } t_tier_row;

    localparam tct_pkg::t_result NONE_RESULT = '{tct_pkg::DEC_NONE, 5'd0, 1'b0, 1'b0};
    localparam tct_pkg::t_result AMP6_RESULT = '{tct_pkg::DEC_SPACE_AMP, 5'd6, 1'b1, 1'b0};

    // Single short list, busy level zero, a space-amp list, a size-ratio list
    // and a reduce-runs list, all under reset register values.
    t_tier_row directed_rows [DIRECTED_ROWS] = '{
        '{'{10'd0,    1'b1, 1'b0}, 1'b1, NONE_RESULT},
        '{'{10'd1023, 1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1023, 1'b0, 1'b1}, 1'b0, NONE_RESULT},
        '{'{10'd1023, 1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1023, 1'b0, 1'b1}, 1'b0, NONE_RESULT},
        '{'{10'd1023, 1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1023, 1'b1, 1'b1}, 1'b1, NONE_RESULT},
        '{'{10'd1,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1,    1'b1, 1'b0}, 1'b1, AMP6_RESULT},
        '{'{10'd1,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd1,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd4,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd5,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd6,    1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd30,   1'b1, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd10,   1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd10,   1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd10,   1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd10,   1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd10,   1'b0, 1'b0}, 1'b0, NONE_RESULT},
        '{'{10'd30,   1'b1, 1'b0}, 1'b0, NONE_RESULT}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tct_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tct_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tct_item_if   item_ch ();
    tct_result_if result_ch ();

    tiered_compaction_trigger u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    // register copies
    logic [tct_pkg::COUNT_CFG_W-1:0] cfg_min_tiers;
    logic [tct_pkg::PCT_W-1:0]       cfg_amp_pct;
    logic [tct_pkg::PCT_W-1:0]       cfg_ratio_pct;
    logic [tct_pkg::COUNT_CFG_W-1:0] cfg_min_width;
    logic [tct_pkg::COUNT_CFG_W-1:0] cfg_max_width;

    // list state
    logic [4:0]                      tiers_seen;
    logic [13:0]                     files_before;
    logic [tct_pkg::RUN_FILES_W-1:0] newest_files;
    logic [4:0]                      ratio_tier;
    logic                            ratio_found;
    logic                            overflowed;

    tct_pkg::t_result decisions_due [$];
    int      mismatch_count;
    int      cycle_count;
    int      tiers_sent;
    int      idle_pct;
    int      stall_pct;
    logic    hold_start;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic bit decide_on_tier(input tct_pkg::t_tier_item it,
                                          output tct_pkg::t_result res);
        int unsigned grown, needed, amp_lhs, amp_rhs;
        logic [4:0]  taken;
        res = NONE_RESULT;
        if (tiers_seen >= tct_pkg::MAX_TIERS_DEF) begin
            overflowed = 1'b1;
        end else begin
            files_before = files_before + newest_files;
            grown  = int'(it.run_files) * int'(tct_pkg::PERCENT_BASE);
            needed = int'(files_before) *
                     (int'(tct_pkg::PERCENT_BASE) + int'(cfg_ratio_pct));
            if (tiers_seen > 0 && !ratio_found && files_before > 0 &&
                tiers_seen >= cfg_min_width && grown > needed) begin
                ratio_found = 1'b1;
                ratio_tier  = tiers_seen;
            end
            newest_files = it.run_files;
            tiers_seen   = tiers_seen + 5'd1;
        end
        if (!it.last_tier)
            return 1'b0;

        amp_lhs = int'(files_before) * int'(tct_pkg::PERCENT_BASE);
        amp_rhs = int'(cfg_amp_pct) * int'(newest_files);
        if (it.level0_busy || tiers_seen < cfg_min_tiers) begin
            res.decision = tct_pkg::DEC_NONE;
        end else if ((newest_files != 0 && amp_lhs >= amp_rhs) ||
                     (newest_files == 0 && cfg_amp_pct == 0)) begin
            res.decision        = tct_pkg::DEC_SPACE_AMP;
            res.tiers_taken     = tiers_seen;
            res.bottom_included = 1'b1;
        end else if (ratio_found) begin
            res.decision    = tct_pkg::DEC_SIZE_RATIO;
            res.tiers_taken = ratio_tier;
        end else begin
            taken = tiers_seen;
            if (cfg_max_width != 0 && cfg_max_width < taken)
                taken = cfg_max_width;
            res.decision        = tct_pkg::DEC_REDUCE_RUNS;
            res.tiers_taken     = taken;
            res.bottom_included = (tiers_seen <= taken);
        end
        res.tier_overflow = overflowed;

        tiers_seen   = '0;
        files_before = '0;
        newest_files = '0;
        ratio_tier   = '0;
        ratio_found  = 1'b0;
        overflowed   = 1'b0;
        return 1'b1;
    endfunction

    task automatic check_result(input tct_pkg::t_result got);
        tct_pkg::t_result want;
        if (decisions_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected decision: dec=%0d taken=%0d bottom=%0d ovf=%0d",
                         got.decision, got.tiers_taken, got.bottom_included,
                         got.tier_overflow);
            return;
        end
        want = decisions_due.pop_front();
        if (got.decision !== want.decision || got.tiers_taken !== want.tiers_taken ||
            got.bottom_included !== want.bottom_included ||
            got.tier_overflow !== want.tier_overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("decision mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                         want.decision, want.tiers_taken, want.bottom_included,
                         want.tier_overflow, got.decision, got.tiers_taken,
                         got.bottom_included, got.tier_overflow);
        end
    endtask

    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                check_result(result_ch.payload);
            if (hold_start && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_tier(input tct_pkg::t_tier_item it, input bit typed,
                             input tct_pkg::t_result want);
        tct_pkg::t_result predicted;
        while ($urandom_range(99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        tiers_sent++;
        if (decide_on_tier(it, predicted))
            decisions_due.insert(decisions_due.size(), typed ? want : predicted);
    endtask

    // Mostly well-formed lists; a few run past capacity.
    task automatic send_random_list();
        int                  len, shape, pick, grown;
        tct_pkg::t_tier_item it;
        logic [9:0]          size;
        pick = $urandom_range(99);
        if (pick < 8)
            len = $urandom_range(tct_pkg::MAX_TIERS_DEF + 4, tct_pkg::MAX_TIERS_DEF + 1);
        else if (pick < 22)
            len = $urandom_range(3, 1);
        else
            len = $urandom_range(tct_pkg::MAX_TIERS_DEF, 4);
        shape = $urandom_range(3);
        size  = 10'($urandom_range(8));
        for (int k = 0; k < len; k++) begin
            case (shape)
                0: size = 10'($urandom_range(1023));
                1: begin
                    // geometric growth, tends to trip the size-ratio compare
                    grown = int'(size) * $urandom_range(4, 1) + $urandom_range(5);
                    if (k > 0)
                        size = (grown > 1023) ? 10'd1023 : 10'(grown);
                end
                2: size = 10'($urandom_range(15));
                default: size = ($urandom_range(2) == 0) ? 10'd0 : 10'($urandom_range(1023));
            endcase
            it.last_tier = (k == len - 1);
            if (it.last_tier) begin
                pick = $urandom_range(9);
                if (pick == 0)
                    size = 10'd0;
                else if (pick == 1)
                    size = 10'd1023;
                it.level0_busy = ($urandom_range(7) == 0);
            end else begin
                it.level0_busy = 1'($urandom_range(1));
            end
            it.run_files = size;
            send_tier(it, 1'b0, NONE_RESULT);
        end
    endtask

    task automatic put_reg(input tct_pkg::t_cfg_idx idx,
                           input logic [tct_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            tct_pkg::CFG_MIN_TIER_COUNT:
                cfg_min_tiers = data[tct_pkg::COUNT_CFG_W-1:0];
            tct_pkg::CFG_MAX_AMP_PERCENT:
                cfg_amp_pct   = data[tct_pkg::PCT_W-1:0];
            tct_pkg::CFG_SIZE_RATIO_PERCENT:
                cfg_ratio_pct = data[tct_pkg::PCT_W-1:0];
            tct_pkg::CFG_MIN_MERGE_WIDTH:
                cfg_min_width = data[tct_pkg::COUNT_CFG_W-1:0];
            tct_pkg::CFG_MAX_MERGE_WIDTH:
                cfg_max_width = data[tct_pkg::COUNT_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int ph);
        logic [tct_pkg::CFG_DATA_W-1:0] v [5];
        case (ph)
            1: v = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd0};
            2: v = '{10'd16, 10'd1000, 10'd1000, 10'd16, 10'd16};
            3: v = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd31};
            4: v = '{10'd2, 10'd1023, 10'd1023, 10'd31, 10'd1};
            NUM_PHASES - 1: begin
                foreach (v[k])
                    v[k] = 10'($urandom_range(1023));
            end
            default: begin
                v[0] = 10'($urandom_range(8, 1));
                v[1] = 10'($urandom_range(1000, 1));
                v[2] = 10'($urandom_range(300, 1));
                v[3] = 10'($urandom_range(6, 1));
                v[4] = 10'($urandom_range(16, 0));
            end
        endcase
        put_reg(tct_pkg::CFG_MIN_TIER_COUNT, v[0]);
        put_reg(tct_pkg::CFG_MAX_AMP_PERCENT, v[1]);
        put_reg(tct_pkg::CFG_SIZE_RATIO_PERCENT, v[2]);
        put_reg(tct_pkg::CFG_MIN_MERGE_WIDTH, v[3]);
        put_reg(tct_pkg::CFG_MAX_MERGE_WIDTH, v[4]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (decisions_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int target;
        mismatch_count  = 0;
        cycle_count     = 0;
        tiers_sent      = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        cfg_min_tiers   = tct_pkg::MIN_TIER_COUNT_RST;
        cfg_amp_pct     = tct_pkg::MAX_AMP_PERCENT_RST;
        cfg_ratio_pct   = tct_pkg::SIZE_RATIO_RST;
        cfg_min_width   = tct_pkg::MIN_MERGE_WIDTH_RST;
        cfg_max_width   = tct_pkg::MAX_MERGE_WIDTH_RST;
        tiers_seen      = '0;
        files_before    = '0;
        newest_files    = '0;
        ratio_tier      = '0;
        ratio_found     = 1'b0;
        overflowed      = 1'b0;
        hold_start      <= 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= tct_pkg::CFG_MIN_TIER_COUNT;
        i_cfg_data      <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                set_config(ph);
            end
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            if (ph == 0) begin
                foreach (directed_rows[r])
                    send_tier(directed_rows[r].item, directed_rows[r].typed,
                              directed_rows[r].want);
            end
            // receiver goes quiet while tiers keep coming
            if (ph == PRESSURE_PHASE)
                hold_start <= 1'b1;
            target = tiers_sent + ITEMS_PER_PHASE;
            while (tiers_sent < target)
                send_random_list();
        end
        drain();

        if (mismatch_count == 0 && decisions_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tct_pkg.sv
hdl/tct_item_if.sv
hdl/tct_result_if.sv
hdl/tiered_compaction_trigger.sv
hdl/tct_checker.sv
dv/testbench.sv
